>>> src/lpdr_pkg.sv
`timescale 1ns / 1ps

package lpdr_pkg;

    localparam int unsigned VAL_W = 31;
    localparam int unsigned IDX_W = 2;

    localparam logic [VAL_W-1:0] LEHMER_MOD   = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] MULT_RESET   = 31'd16087;
    localparam logic [VAL_W-1:0] SEED_RESET   = 31'd1234;
    localparam logic [VAL_W-1:0] LIMIT_RESET  = 31'd3;

    // ceil(2^35 / 10), exact quotient for any 32-bit dividend after >> 35
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    localparam logic [IDX_W-1:0] REG_MULTIPLIER  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SEED_VALUE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_RANGE_LIMIT = 2'd2;

    typedef struct packed {
        logic mul_en;
        logic red_en;
        logic dig_step;
        logic out_load;
    } lpdr_cmd_t;

    typedef struct packed {
        logic dig_more;
    } lpdr_sts_t;

endpackage

>>> src/lpdr_dp.sv
`timescale 1ns / 1ps

module lpdr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [lpdr_pkg::IDX_W-1:0]    wr_index,
    input  logic [lpdr_pkg::VAL_W-1:0]    wr_data,
    input  lpdr_pkg::lpdr_cmd_t           cmd,
    output lpdr_pkg::lpdr_sts_t           sts,
    output logic [lpdr_pkg::VAL_W-1:0]    bounded_value,
    output logic [lpdr_pkg::VAL_W-1:0]    raw_state
);
    import lpdr_pkg::*;

    logic [VAL_W-1:0]   mult_reg;
    logic [VAL_W-1:0]   limit_reg;
    logic [VAL_W-1:0]   gen_reg;
    logic [VAL_W-1:0]   gen_next;
    logic [2*VAL_W-1:0] prod_reg;
    logic [2*VAL_W-1:0] prod_next;
    logic [VAL_W-1:0]   x_reg;
    logic [VAL_W-1:0]   x_next;
    logic [VAL_W-1:0]   bounded_reg;
    logic [VAL_W-1:0]   raw_reg;
    logic [VAL_W:0]     fold1;
    logic [VAL_W-1:0]   fold2;
    logic [VAL_W-1:0]   reduced;
    logic [62:0]        div_prod;

    assign prod_next = mult_reg * gen_reg;

    // 2^31 = 1 mod (2^31-1): add the high half onto the low half, twice
    assign fold1   = {1'b0, prod_reg[2*VAL_W-1:VAL_W]} + {1'b0, prod_reg[VAL_W-1:0]};
    assign fold2   = fold1[VAL_W-1:0] + {{(VAL_W-1){1'b0}}, fold1[VAL_W]};
    assign reduced = (fold2 == LEHMER_MOD) ? '0 : fold2;

    // divide by ten through the reciprocal
    assign div_prod = x_reg * RECIP10;
    assign x_next   = {3'b000, div_prod[62:RECIP10_SHIFT]};

    assign sts.dig_more = (x_reg > limit_reg);

    always_comb
    begin
        gen_next = gen_reg;
        if (wr_en && (wr_index == REG_SEED_VALUE))
        begin
            gen_next = (wr_data == LEHMER_MOD) ? '0 : wr_data;
        end
        else if (cmd.red_en)
        begin
            gen_next = reduced;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg  <= MULT_RESET;
            limit_reg <= LIMIT_RESET;
            gen_reg   <= SEED_RESET;
        end
        else
        begin
            gen_reg <= gen_next;
            if (wr_en && (wr_index == REG_MULTIPLIER))
            begin
                mult_reg <= wr_data;
            end
            if (wr_en && (wr_index == REG_RANGE_LIMIT))
            begin
                limit_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.red_en)
        begin
            x_reg <= reduced;
        end
        else if (cmd.dig_step)
        begin
            x_reg <= x_next;
        end
        if (cmd.out_load)
        begin
            // after the digit loop x never exceeds the limit, so the modulo is one compare
            bounded_reg <= (x_reg == limit_reg) ? '0 : x_reg;
            raw_reg     <= gen_reg;
        end
    end

    assign bounded_value = bounded_reg;
    assign raw_state     = raw_reg;

endmodule

>>> src/lpdr_ctrl.sv
`timescale 1ns / 1ps

module lpdr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 draw,
    input  logic                 out_stall,
    input  lpdr_pkg::lpdr_sts_t  sts,
    output lpdr_pkg::lpdr_cmd_t  cmd,
    output logic                 in_stall,
    output logic                 out_valid
);
    import lpdr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_RED,
        S_DIG
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // the result register can take a new item when empty or being read out
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && draw)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.red_en = 1'b1;
                state_next = S_DIG;
            end
            S_DIG:
            begin
                if (sts.dig_more)
                begin
                    cmd.dig_step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/lehmer_prng_digit_reduced.sv
`timescale 1ns / 1ps

// Lehmer generator modulo 2^31-1 with a digit-reduced bounded output.
// Input channel (in_valid / in_stall, field draw): an item with draw = 1
// asks for one value, an item with draw = 0 is taken and gives nothing.
// Output channel (out_valid / out_stall): one item per draw, carrying
// bounded_value and raw_state, held steady while out_stall is high.
// Configuration: wr_en with wr_index 0 = multiplier, 1 = seed (also loads
// the generator state, the modulus itself loads as 0), 2 = range limit;
// other indexes are ignored. Write only while no draw is in progress.
// Steps: after the accept edge, a registered multiply (31x31 product), a
// modular fold, one divide-by-ten per step of the digit loop (none to ten
// steps, one reciprocal multiply each) and the load of the result register,
// which waits while that register is still full and stalled. One draw is in
// flight: no new item is taken until the result is loaded.
// A new item is taken while the previous result still waits; if the
// receiver stalls, the next draw finishes and holds until the result
// register frees. Reset loads multiplier 16087, seed and state 1234 and
// limit 3, and empties the output.
module lehmer_prng_digit_reduced (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       draw,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lpdr_pkg::VAL_W-1:0] bounded_value,
    output logic [lpdr_pkg::VAL_W-1:0] raw_state,
    input  logic                       wr_en,
    input  logic [lpdr_pkg::IDX_W-1:0] wr_index,
    input  logic [lpdr_pkg::VAL_W-1:0] wr_data
);
    import lpdr_pkg::*;

    lpdr_cmd_t cmd;
    lpdr_sts_t sts;

    lpdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .draw      (draw),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    lpdr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .cmd           (cmd),
        .sts           (sts),
        .bounded_value (bounded_value),
        .raw_state     (raw_state)
    );

endmodule
